// File: rtl/smah_pkg.sv
// Shared constants for the stereo moving-average high-pass block.
package smah_pkg;

    localparam int RING_DEPTH   = 1024;
    localparam int ADDR_BITS    = 10;
    localparam int SAMPLE_BITS  = 16;
    localparam int OUT_BITS     = SAMPLE_BITS + 1;
    localparam int SUM_BITS     = 26;
    localparam int WIN_BITS     = 11;
    localparam int WIN_RESET    = 31;
    localparam int S_TDATA_BITS = 2 * SAMPLE_BITS;
    localparam int M_TDATA_BITS = 40;
    localparam int RAM_BITS     = 2 * SAMPLE_BITS;

    localparam logic ACT_PROCESS = 1'b0;
    localparam logic ACT_FLUSH   = 1'b1;

endpackage

// File: rtl/stereo_moving_average_highpass.sv
// Top level of the stereo moving-average high-pass filter.
// Path from an accepted sample pair to tvalid: ring read, sum update, bit-serial dividers,
// output load (held off by output backpressure); a new pair is taken only after that load.
// A flush runs a clearing pass that writes zero to every one of the 1024 ring entries.
// Outside a clearing pass, a window write rebuilds both sums by reading back L ring entries.
// Reset (rst_n, async) runs the same clearing pass; tready stays low meanwhile.
module stereo_moving_average_highpass
    import smah_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [S_TDATA_BITS-1:0] s_axis_tdata,  // left_sample, right_sample
    input  logic [0:0]              s_axis_tuser,  // action
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [M_TDATA_BITS-1:0] m_axis_tdata,  // left_out, right_out, zero pad
    input  logic                    cfg_wr_en,
    input  logic [WIN_BITS-1:0]     cfg_wr_data
);

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_OLD,
        S_UPD,
        S_DIV,
        S_RB
    } state_t;

    localparam int PAD_BITS = M_TDATA_BITS - 2 * OUT_BITS;

    function automatic logic [WIN_BITS-1:0] eff_window(input logic [WIN_BITS-1:0] w);
        logic [WIN_BITS-1:0] r;
        r = w;
        if (w == '0)
        begin
            r = WIN_BITS'(1);
        end
        else if (w > WIN_BITS'(RING_DEPTH))
        begin
            r = WIN_BITS'(RING_DEPTH);
        end
        return r;
    endfunction

    state_t                         state_reg, state_next;
    logic [WIN_BITS-1:0]            win_reg, win_next;
    logic [ADDR_BITS-1:0]           pos_reg, pos_next;
    logic signed [SUM_BITS-1:0]     lsum_reg, lsum_next;
    logic signed [SUM_BITS-1:0]     rsum_reg, rsum_next;
    logic signed [SAMPLE_BITS-1:0]  lsmp_reg, lsmp_next;
    logic signed [SAMPLE_BITS-1:0]  rsmp_reg, rsmp_next;
    logic [ADDR_BITS-1:0]           clr_addr_reg, clr_addr_next;
    logic [ADDR_BITS-1:0]           rb_addr_reg, rb_addr_next;
    logic [WIN_BITS-1:0]            rb_left_reg, rb_left_next;
    logic                           rb_pend_reg, rb_pend_next;
    logic                           out_valid_reg, out_valid_next;
    logic [M_TDATA_BITS-1:0]        out_data_reg, out_data_next;

    logic [WIN_BITS-1:0]            eff_len;
    logic                           ram_wr_en;
    logic [ADDR_BITS-1:0]           ram_wr_addr;
    logic [RAM_BITS-1:0]            ram_wr_data;
    logic [ADDR_BITS-1:0]           ram_rd_addr;
    logic [RAM_BITS-1:0]            ram_rd_data;
    logic signed [SAMPLE_BITS-1:0]  old_l, old_r;
    logic                           div_start;
    logic                           ldiv_busy, rdiv_busy;
    logic signed [SUM_BITS-1:0]     lquo, rquo;
    logic [OUT_BITS-1:0]            lout, rout;
    logic                           in_xact;

    assign eff_len = eff_window(win_reg);
    assign old_l   = $signed(ram_rd_data[SAMPLE_BITS-1:0]);
    assign old_r   = $signed(ram_rd_data[RAM_BITS-1:SAMPLE_BITS]);
    assign in_xact = s_axis_tvalid && s_axis_tready;

    assign lout = OUT_BITS'(lsmp_reg) - lquo[OUT_BITS-1:0];
    assign rout = OUT_BITS'(rsmp_reg) - rquo[OUT_BITS-1:0];

    // ring RAM ports
    always_comb
    begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = pos_reg;
        ram_wr_data = {rsmp_reg, lsmp_reg};
        ram_rd_addr = rb_addr_reg;
        unique case (state_reg)
            S_CLR:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = clr_addr_reg;
                ram_wr_data = '0;
            end
            S_OLD:
            begin
                ram_rd_addr = pos_reg - eff_len[ADDR_BITS-1:0];
            end
            S_UPD:
            begin
                ram_wr_en = 1'b1;
            end
            S_IDLE, S_DIV, S_RB:
            begin
                ram_wr_en = 1'b0;
            end
            default:
            begin
                ram_wr_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        win_next       = win_reg;
        pos_next       = pos_reg;
        lsum_next      = lsum_reg;
        rsum_next      = rsum_reg;
        lsmp_next      = lsmp_reg;
        rsmp_next      = rsmp_reg;
        clr_addr_next  = clr_addr_reg;
        rb_addr_next   = rb_addr_reg;
        rb_left_next   = rb_left_reg;
        rb_pend_next   = rb_pend_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        div_start      = 1'b0;

        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == {ADDR_BITS{1'b1}})
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    lsmp_next = $signed(s_axis_tdata[SAMPLE_BITS-1:0]);
                    rsmp_next = $signed(s_axis_tdata[S_TDATA_BITS-1:SAMPLE_BITS]);
                    if (s_axis_tuser[0] == ACT_FLUSH)
                    begin
                        lsum_next     = '0;
                        rsum_next     = '0;
                        clr_addr_next = '0;
                        state_next    = S_CLR;
                    end
                    else
                    begin
                        state_next = S_OLD;
                    end
                end
            end
            S_OLD:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                // drop the sample leaving the window, add the new one
                lsum_next  = lsum_reg - SUM_BITS'(old_l) + SUM_BITS'(lsmp_reg);
                rsum_next  = rsum_reg - SUM_BITS'(old_r) + SUM_BITS'(rsmp_reg);
                pos_next   = pos_reg + 1'b1;
                div_start  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (!ldiv_busy && !rdiv_busy && (!out_valid_reg || m_axis_tready))
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {{PAD_BITS{1'b0}}, rout, lout};
                    state_next     = S_IDLE;
                end
            end
            S_RB:
            begin
                if (rb_left_reg != '0)
                begin
                    rb_addr_next = rb_addr_reg - 1'b1;
                    rb_left_next = rb_left_reg - 1'b1;
                    rb_pend_next = 1'b1;
                end
                else
                begin
                    rb_pend_next = 1'b0;
                end
                if (rb_pend_reg)
                begin
                    lsum_next = lsum_reg + SUM_BITS'(old_l);
                    rsum_next = rsum_reg + SUM_BITS'(old_r);
                end
                if (rb_left_reg == '0 && !rb_pend_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_wr_en)
        begin
            win_next = cfg_wr_data;
            // a clearing pass leaves zero sums whatever the window
            if (state_reg != S_CLR)
            begin
                lsum_next    = '0;
                rsum_next    = '0;
                rb_addr_next = pos_reg - 1'b1;
                rb_left_next = eff_window(cfg_wr_data);
                rb_pend_next = 1'b0;
                state_next   = S_RB;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            win_reg       <= WIN_BITS'(WIN_RESET);
            pos_reg       <= '0;
            lsum_reg      <= '0;
            rsum_reg      <= '0;
            lsmp_reg      <= '0;
            rsmp_reg      <= '0;
            clr_addr_reg  <= '0;
            rb_addr_reg   <= '0;
            rb_left_reg   <= '0;
            rb_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            win_reg       <= win_next;
            pos_reg       <= pos_next;
            lsum_reg      <= lsum_next;
            rsum_reg      <= rsum_next;
            lsmp_reg      <= lsmp_next;
            rsmp_reg      <= rsmp_next;
            clr_addr_reg  <= clr_addr_next;
            rb_addr_reg   <= rb_addr_next;
            rb_left_reg   <= rb_left_next;
            rb_pend_reg   <= rb_pend_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    smah_ram #(
        .WIDTH (RAM_BITS),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    smah_div u_ldiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (lsum_next),
        .divisor  (eff_len),
        .busy     (ldiv_busy),
        .quotient (lquo)
    );

    smah_div u_rdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (rsum_next),
        .divisor  (eff_len),
        .busy     (rdiv_busy),
        .quotient (rquo)
    );

    assign s_axis_tready = (state_reg == S_IDLE) && !cfg_wr_en;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // the block takes one pair at a time
    a_busy_after_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_xact |=> !s_axis_tready)
        else $error("input accepted on consecutive cycles");

    // a result appears only when the dividers finish
    a_out_from_div: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == S_DIV))
        else $error("result loaded outside the divide phase");

    // both channel dividers run in lockstep
    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        ldiv_busy == rdiv_busy)
        else $error("channel dividers out of step");

    // a flush starts a clearing pass
    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xact && s_axis_tuser[0] == ACT_FLUSH) |=> (state_reg == S_CLR))
        else $error("flush did not start a clearing pass");

endmodule

// File: rtl/smah_ram.sv
// Generic simple dual-port RAM with registered read.
module smah_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: rtl/smah_div.sv
// Bit-serial restoring divider: signed sum over unsigned window, truncated toward zero.
module smah_div
    import smah_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic signed [SUM_BITS-1:0] dividend,
    input  logic [WIN_BITS-1:0]        divisor,
    output logic                       busy,
    output logic signed [SUM_BITS-1:0] quotient
);

    localparam int CNT_BITS = $clog2(SUM_BITS + 1);

    logic                  busy_reg, busy_next;
    logic                  neg_reg, neg_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic [SUM_BITS-1:0]   mag_reg, mag_next;
    logic [WIN_BITS-1:0]   rem_reg, rem_next;
    logic [WIN_BITS-1:0]   dvs_reg, dvs_next;
    logic [WIN_BITS:0]     rem_sh;
    logic [WIN_BITS:0]     rem_sub;

    assign rem_sh  = {rem_reg, mag_reg[SUM_BITS-1]};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        mag_next  = mag_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            neg_next  = dividend[SUM_BITS-1];
            mag_next  = dividend[SUM_BITS-1] ? SUM_BITS'(-dividend) : SUM_BITS'(dividend);
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = CNT_BITS'(SUM_BITS);
        end
        else if (busy_reg)
        begin
            // one quotient bit per cycle, shifted into the dividend register
            if (rem_sh >= {1'b0, dvs_reg})
            begin
                rem_next = rem_sub[WIN_BITS-1:0];
                mag_next = {mag_reg[SUM_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[WIN_BITS-1:0];
                mag_next = {mag_reg[SUM_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            neg_reg  <= 1'b0;
            cnt_reg  <= '0;
            mag_reg  <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            neg_reg  <= neg_next;
            cnt_reg  <= cnt_next;
            mag_reg  <= mag_next;
            rem_reg  <= rem_next;
            dvs_reg  <= dvs_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = neg_reg ? -$signed(mag_reg) : $signed(mag_reg);

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the stereo moving-average high-pass filter.
module testbench
    import smah_pkg::*;
();

    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int SETTLE_CYCLES   = 1100;
    localparam int ITEMS_PER_PHASE = 145;
    localparam int DIRECTED_COUNT  = 18;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] left;
        logic signed [OUT_BITS-1:0] right;
    } out_pair_t;

    typedef struct packed {
        logic                       act;
        logic [SAMPLE_BITS-1:0]     left;
        logic [SAMPLE_BITS-1:0]     right;
        logic                       typed;
        logic signed [OUT_BITS-1:0] exp_left;
        logic signed [OUT_BITS-1:0] exp_right;
    } stim_row_t;

    // Directed rows run at the reset window of 31 samples.
    localparam stim_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        '{ACT_PROCESS, 16'h0000, 16'h0000, 1'b1, 17'sd0, 17'sd0},
        '{ACT_PROCESS, 16'h7fff, 16'h8000, 1'b0, 17'sd0, 17'sd0},
        '{ACT_PROCESS, 16'h8000, 16'h7fff, 1'b0, 17'sd0, 17'sd0},
        '{ACT_PROCESS, 16'hffff, 16'h0001, 1'b0, 17'sd0, 17'sd0},
        '{ACT_PROCESS, 16'h5555, 16'haaaa, 1'b0, 17'sd0, 17'sd0},
        '{ACT_PROCESS, 16'haaaa, 16'h5555, 1'b0, 17'sd0, 17'sd0},
        '{ACT_PROCESS, 16'h7fff, 16'h7fff, 1'b0, 17'sd0, 17'sd0},
        '{ACT_PROCESS, 16'h7fff, 16'h7fff, 1'b0, 17'sd0, 17'sd0},
        '{ACT_PROCESS, 16'h7fff, 16'h7fff, 1'b0, 17'sd0, 17'sd0},
        '{ACT_PROCESS, 16'h8000, 16'h8000, 1'b0, 17'sd0, 17'sd0},
        '{ACT_FLUSH,   16'h0000, 16'h0000, 1'b0, 17'sd0, 17'sd0},
        '{ACT_PROCESS, 16'h0000, 16'h0000, 1'b1, 17'sd0, 17'sd0},
        '{ACT_PROCESS, 16'h8000, 16'h8000, 1'b0, 17'sd0, 17'sd0},
        '{ACT_PROCESS, 16'h8000, 16'h8000, 1'b0, 17'sd0, 17'sd0},
        '{ACT_PROCESS, 16'h8000, 16'h7fff, 1'b0, 17'sd0, 17'sd0},
        '{ACT_PROCESS, 16'h7fff, 16'h8000, 1'b0, 17'sd0, 17'sd0},
        '{ACT_FLUSH,   16'hffff, 16'hffff, 1'b0, 17'sd0, 17'sd0},
        '{ACT_PROCESS, 16'h0001, 16'hffff, 1'b0, 17'sd0, 17'sd0}
    };

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [S_TDATA_BITS-1:0] s_axis_tdata;   // left_sample, right_sample
    logic [0:0]              s_axis_tuser;   // action
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [M_TDATA_BITS-1:0] m_axis_tdata;   // left_out, right_out, zero pad
    logic                    cfg_wr_en;
    logic [WIN_BITS-1:0]     cfg_wr_data;

    // Filter state as the block should hold it.
    logic signed [SAMPLE_BITS-1:0] left_hist [RING_DEPTH];
    logic signed [SAMPLE_BITS-1:0] right_hist [RING_DEPTH];
    longint                        left_acc;
    longint                        right_acc;
    int                            wr_pos;
    logic [WIN_BITS-1:0]           win_reg;

    out_pair_t highpass_due [$];
    int        error_count = 0;
    int        idle_cycles = 0;
    bit        quiet = 1'b0;

    stereo_moving_average_highpass i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int window_used();
        if (win_reg == 0)
            return 1;
        if (win_reg > RING_DEPTH)
            return RING_DEPTH;
        return int'(win_reg);
    endfunction

    function automatic void rebuild_window_sums();
        int len;
        int idx;
        len = window_used();
        left_acc = 0;
        right_acc = 0;
        for (int i = 1; i <= len; i++)
        begin
            idx = (wr_pos + RING_DEPTH - i) % RING_DEPTH;
            left_acc += left_hist[idx];
            right_acc += right_hist[idx];
        end
    endfunction

    // Advance the filter by one transaction; return 1 when it yields an output pair.
    function automatic bit step_highpass(input logic act,
                                         input logic signed [SAMPLE_BITS-1:0] l,
                                         input logic signed [SAMPLE_BITS-1:0] r,
                                         output out_pair_t res);
        int     len;
        int     old_idx;
        longint diff_l;
        longint diff_r;
        res = '0;
        if (act == ACT_FLUSH)
        begin
            for (int i = 0; i < RING_DEPTH; i++)
            begin
                left_hist[i] = '0;
                right_hist[i] = '0;
            end
            left_acc = 0;
            right_acc = 0;
            return 1'b0;
        end
        len = window_used();
        // With a full window the departing sample sits in the slot being overwritten.
        old_idx = (wr_pos + RING_DEPTH - len) % RING_DEPTH;
        left_acc -= left_hist[old_idx];
        right_acc -= right_hist[old_idx];
        left_hist[wr_pos] = l;
        right_hist[wr_pos] = r;
        left_acc += l;
        right_acc += r;
        wr_pos = (wr_pos + 1) % RING_DEPTH;
        diff_l = longint'(l) - left_acc / len;
        diff_r = longint'(r) - right_acc / len;
        res.left = diff_l[OUT_BITS-1:0];
        res.right = diff_r[OUT_BITS-1:0];
        return 1'b1;
    endfunction

    function automatic int idle_len();
        int pick;
        if (quiet)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return $urandom_range(1, 3);
        if (pick < 95)
            return $urandom_range(4, 20);
        return $urandom_range(50, 300);
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] extreme_sample();
        case ($urandom_range(0, 3))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'hffff;
            default: return 16'h0000;
        endcase
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] random_sample();
        int pick;
        int small_val;
        pick = $urandom_range(0, 9);
        if (pick < 2)
            return extreme_sample();
        if (pick < 5)
        begin
            small_val = int'($urandom_range(0, 600)) - 300;
            return small_val[SAMPLE_BITS-1:0];
        end
        return SAMPLE_BITS'($urandom());
    endfunction

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_pair(input logic act, input logic [SAMPLE_BITS-1:0] l,
                             input logic [SAMPLE_BITS-1:0] r, input bit typed,
                             input out_pair_t typed_res);
        int        gap;
        out_pair_t res;
        gap = ($urandom_range(0, 1) == 1) ? idle_len() : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= act;
        s_axis_tdata <= {r, l};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (step_highpass(act, l, r, res))
            highpass_due.push_back(typed ? typed_res : res);
        @(negedge clk);
    endtask

    // Called at a falling edge with the sender idle.
    task automatic write_window(input logic [WIN_BITS-1:0] value);
        s_axis_tvalid <= 1'b0;
        while (highpass_due.size() != 0)
            @(negedge clk);
        // Cover a flush clearing pass that produces no output.
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        win_reg = value;
        rebuild_window_sums();
    endtask

    // Output side: random backpressure.
    initial
    begin
        int hold;
        hold = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold == 0 && !quiet && $urandom_range(0, 99) < 15)
                hold = idle_len();
            if (hold > 0)
            begin
                m_axis_tready <= 1'b0;
                hold--;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (highpass_due.size() == 0)
            begin
                $error("unexpected output transaction: tdata %h", m_axis_tdata);
                error_count++;
            end
            else
            begin
                out_pair_t want;
                want = highpass_due.pop_front();
                if (m_axis_tdata[OUT_BITS-1:0] !== want.left)
                begin
                    $error("left_out: expected %0d, got %0d", want.left,
                           $signed(m_axis_tdata[OUT_BITS-1:0]));
                    error_count++;
                end
                if (m_axis_tdata[2*OUT_BITS-1:OUT_BITS] !== want.right)
                begin
                    $error("right_out: expected %0d, got %0d", want.right,
                           $signed(m_axis_tdata[2*OUT_BITS-1:OUT_BITS]));
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        logic [WIN_BITS-1:0]    window_plan [$];
        logic                   act;
        logic [SAMPLE_BITS-1:0] run_l;
        logic [SAMPLE_BITS-1:0] run_r;
        int                     run_left;
        stim_row_t              row;

        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = ACT_PROCESS;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        for (int i = 0; i < RING_DEPTH; i++)
        begin
            left_hist[i] = '0;
            right_hist[i] = '0;
        end
        left_acc = 0;
        right_acc = 0;
        wr_pos = 0;
        win_reg = WIN_BITS'(WIN_RESET);
        run_left = 0;
        run_l = '0;
        run_r = '0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED_ROWS[k])
        begin
            row = DIRECTED_ROWS[k];
            send_pair(row.act, row.left, row.right, row.typed,
                      '{left: row.exp_left, right: row.exp_right});
        end

        // Window plan: both ends, zero, beyond the ring, and a few ordinary sizes.
        window_plan = '{11'd1, 11'd0, 11'd2, 11'd1024, 11'd2047, 11'd1025, 11'd3};
        window_plan.push_back(WIN_BITS'($urandom_range(4, 64)));
        window_plan.push_back(11'd512);
        window_plan.push_back(WIN_BITS'($urandom_range(4, 64)));
        window_plan.push_back(11'd1023);
        window_plan.push_back(WIN_BITS'($urandom_range(65, 2047)));
        window_plan.push_back(11'd31);

        foreach (window_plan[p])
        begin
            write_window(window_plan[p]);
            quiet = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                act = ($urandom_range(0, 99) < 2) ? ACT_FLUSH : ACT_PROCESS;
                // Hold an extreme level (full scale, -1 or zero) now and then to push the sums to their limits.
                if (run_left == 0 && $urandom_range(0, 99) < 3)
                begin
                    run_left = $urandom_range(10, 60);
                    run_l = extreme_sample();
                    run_r = extreme_sample();
                end
                if (run_left > 0)
                begin
                    run_left--;
                    send_pair(act, run_l, run_r, 1'b0, '0);
                end
                else
                    send_pair(act, random_sample(), random_sample(), 1'b0, '0);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (highpass_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
